// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/crcl_pkg.sv =====
// ----------------------------------------------------------------------------
// crcl_pkg
// Types, register codes and the CRC byte step for the checksum block.
// ----------------------------------------------------------------------------
package crcl_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE_INVERT       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_POST_INVERT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECTED_ORDER  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCLUDE_LENGTH   = 2'd3;

  // Item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // CRC-32 polynomials
  localparam logic [31:0] POLY_MSB = 32'h04C1_1DB7;
  localparam logic [31:0] POLY_LSB = 32'hEDB8_8320;

  typedef struct packed {
    logic pre_invert;
    logic skip_post_invert;
    logic reflected_order;
    logic exclude_length;
  } cfg_t;

  // Queue entry: the item plus the settings in force when it was accepted
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    cfg_t       cfg;
  } item_t;

  // Status of the back end, watched by the top level
  typedef struct packed {
    logic folding;
    logic result_load;
  } back_status_t;

  // One byte through the CRC, bit by bit (eight shift/xor steps)
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b, logic refl);
    logic [31:0] c;
    if (refl) begin
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ POLY_LSB) : (c >> 1);
      end
    end else begin
      c = crc ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ((c << 1) ^ POLY_MSB) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crcl_front.sv =====
// ----------------------------------------------------------------------------
// crcl_front
// Input side: takes items, tags them with the current settings and queues
// them for the back end.
// ----------------------------------------------------------------------------
module crcl_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                kind,
  input  logic [7:0]          data_byte,
  input  crcl_pkg::cfg_t      cfg,
  output logic                item_valid,
  output crcl_pkg::item_t     item,
  input  logic                item_take
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  crcl_pkg::item_t  entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full       = (count == DEPTH_CNT);
  assign item_valid = (count != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;
  assign item       = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= '{kind: kind, data_byte: data_byte, cfg: cfg};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/crcl_back.sv =====
// ----------------------------------------------------------------------------
// crcl_back
// Back end: runs the CRC over data bytes, folds the length in at end of
// message unless excluded, and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module crcl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  crcl_pkg::item_t       item,
  output logic                  item_take,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           checksum,
  output logic [63:0]           byte_count,
  output crcl_pkg::back_status_t status
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_FOLD = 2'b10
  } state_t;

  state_t         state;
  logic [31:0]    crc;
  logic [63:0]    len;
  logic [63:0]    rest;
  logic           started;
  crcl_pkg::cfg_t cfg_cap;
  logic           out_valid;
  logic [31:0]    base_crc;
  logic [63:0]    base_len;
  logic           slot_free;
  logic           load;

  // Message preset on its first item
  assign base_crc = started ? crc : {32{item.cfg.pre_invert}};
  assign base_len = started ? len : 64'd0;

  assign item_take = (state == ST_RUN) && item_valid;
  assign slot_free = !out_valid || pop;
  assign load      = (state == ST_FOLD) && (rest == 64'd0) && slot_free;
  assign empty     = !out_valid;

  assign status.folding     = (state == ST_FOLD);
  assign status.result_load = load;

  // Engine and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      started <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (item_take) begin
            if (item.kind == crcl_pkg::KIND_DATA) begin
              crc     <= crcl_pkg::crc_byte(base_crc, item.data_byte,
                                            item.cfg.reflected_order);
              len     <= base_len + 64'd1;
              started <= 1'b1;
            end else begin
              crc     <= base_crc;
              len     <= base_len;
              rest    <= item.cfg.exclude_length ? 64'd0 : base_len;
              cfg_cap <= item.cfg;
              started <= 1'b1;
              state   <= ST_FOLD;
            end
          end
        end
        ST_FOLD: begin
          // one count byte a cycle, low byte first, while any remain
          if (rest != 64'd0) begin
            crc  <= crcl_pkg::crc_byte(crc, rest[7:0], cfg_cap.reflected_order);
            rest <= rest >> 8;
          end else if (slot_free) begin
            crc     <= 32'd0;
            len     <= 64'd0;
            started <= 1'b0;
            state   <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      checksum   <= cfg_cap.skip_post_invert ? crc : ~crc;
      byte_count <= cfg_cap.exclude_length ? 64'd0 : len;
    end
  end

endmodule

// ===== src/crc32_checksum_with_length_core.sv =====
// ----------------------------------------------------------------------------
// crc32_checksum_with_length_core
// CRC-32 checksum over a byte stream, byte count folded in unless excluded.
// ----------------------------------------------------------------------------
// Input channel: push/full with kind and data_byte. A data byte (kind 0)
// updates the running CRC and count; an end mark (kind 1) closes the message.
// Result channel: empty/pop with checksum and byte_count, one result per
// end mark, none per data byte.
// Configuration: cfg_we/cfg_index/cfg_data write the four 1-bit settings;
// each item carries the settings present when it is accepted.
// Throughput: one data byte per cycle while the engine is not busy with an
// end mark, which holds it while the k significant bytes of the count
// (k = 0 to 8) are folded in, and after that until the result slot is free.
// Result: once the count bytes are folded, the result register loads and
// empty falls; the engine then goes back to taking items.
// Stalls: a waiting result holds the engine at its end mark; the input queue
// (QUEUE_DEPTH entries) keeps taking items until it fills, then full rises.
// Reset: synchronous; clears the queue, the result valid flag, the message
// state and all settings to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32_checksum_with_length_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             kind,
  input  logic [7:0]                       data_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [31:0]                      checksum,
  output logic [63:0]                      byte_count,
  input  logic                             cfg_we,
  input  logic [crcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data
);

  crcl_pkg::cfg_t         cfg;
  crcl_pkg::item_t        item;
  crcl_pkg::back_status_t status;
  logic                   item_valid;
  logic                   item_take;

  // Settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crcl_pkg::REG_PRE_INVERT:       cfg.pre_invert       <= cfg_data;
        crcl_pkg::REG_SKIP_POST_INVERT: cfg.skip_post_invert <= cfg_data;
        crcl_pkg::REG_REFLECTED_ORDER:  cfg.reflected_order  <= cfg_data;
        crcl_pkg::REG_EXCLUDE_LENGTH:   cfg.exclude_length   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: input queue
  crcl_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .data_byte  (data_byte),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Back: CRC engine and result register
  crcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .checksum   (checksum),
    .byte_count (byte_count),
    .status     (status)
  );

  // Checks on the engine's own sequencing
  `ASSERT_NOW(a_take_needs_item, item_take, item_valid, "engine took from an empty queue")
  `ASSERT_NOW(a_no_take_folding, status.folding, !item_take, "engine took an item while folding")
  `ASSERT_NEXT(a_load_shows, status.result_load, !empty, "loaded result not presented")
  `ASSERT_NOW(a_result_from_fold, $fell(empty), $past(status.folding), "result without end mark")

endmodule
